### hw/rtl/srm_pkg.sv
// Shared types and constants for the sensor report and alarm monitor.
// No dependencies; taken in by srm_elapsed and the monitor core.
package srm_pkg;

	localparam int TIME_W   = 32;  // millisecond time stamp
	localparam int THRESH_W = 23;  // change threshold register
	localparam int CYCLE_W  = 8;   // cyclic period in minutes
	localparam int MSPM_W   = 16;  // width of the ms-per-minute factor
	localparam int IDX_W    = 3;   // register index

	// min/max start-up value, saturated to the value range at elaboration
	localparam longint MINMAX_INIT = 100000;

	typedef enum logic [IDX_W-1:0] {
		REG_SEND_CYCLE = 3'd0,
		REG_THRESHOLD  = 3'd1,
		REG_OFFSET     = 3'd2,
		REG_WARN_LOW   = 3'd3,
		REG_WARN_HIGH  = 3'd4,
		REG_MINMAX_EN  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		REQ_SAMPLE       = 1'b0,
		REQ_MINMAX_RESET = 1'b1
	} req_kind_t;

endpackage

### hw/rtl/srm_if.sv
// Valid/ready channel interfaces for sample requests and reports.
// Depends on nothing; widths follow the VALUE_BITS parameter.
interface srm_req_if #(parameter int VALUE_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic signed [VALUE_BITS-1:0] sample_value;
	logic                         sample_valid;
	logic [31:0]                  now_ms;

	modport source (output valid, req_type, sample_value, sample_valid, now_ms,
		input ready);
	modport sink (input valid, req_type, sample_value, sample_valid, now_ms,
		output ready);
endinterface

interface srm_rsp_if #(parameter int VALUE_BITS = 24);
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] reported_value;
	logic                         value_sent;
	logic signed [VALUE_BITS-1:0] min_value;
	logic signed [VALUE_BITS-1:0] max_value;
	logic                         alarm_high;
	logic                         alarm_high_sent;
	logic                         alarm_low;
	logic                         alarm_low_sent;

	modport source (output valid, reported_value, value_sent, min_value, max_value,
		alarm_high, alarm_high_sent, alarm_low, alarm_low_sent, input ready);
	modport sink (input valid, reported_value, value_sent, min_value, max_value,
		alarm_high, alarm_high_sent, alarm_low, alarm_low_sent, output ready);
endinterface

### hw/rtl/srm_elapsed.sv
// Period expiry test: time since a stamp, modulo 2^32, exceeds the period.
// Depends on srm_pkg.
module srm_elapsed (
	input  logic [srm_pkg::TIME_W-1:0] now,
	input  logic [srm_pkg::TIME_W-1:0] since,
	input  logic [srm_pkg::TIME_W-1:0] period,
	output logic                       expired
);
	import srm_pkg::*;

	logic [TIME_W-1:0] delta;

	assign delta   = now - since;  // wraps naturally
	assign expired = delta > period;
endmodule

### hw/rtl/sensor_report_and_alarm_monitor_core.sv
// Send-on-delta monitor with cyclic report, min/max tracking and alarms.
// Path: a request transfer loads the input register, which moves on into the report
// register when that is empty or being drained. Throughput: one request per cycle,
// set by the single evaluation pass between the two registers; request ready falls
// only while both registers are full and the report is stalled.
// Reset (arst_n low, asynchronous): valid flags, configuration and channel state
// cleared, min/max start at the saturated +/-1000.00 units, no transfer pending.
module sensor_report_and_alarm_monitor_core #(
	parameter int VALUE_BITS    = 24,
	parameter int MS_PER_MINUTE = 60000,
	localparam int CFG_W = (VALUE_BITS > srm_pkg::THRESH_W) ? VALUE_BITS : srm_pkg::THRESH_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [srm_pkg::IDX_W-1:0]     wr_index,
	input  logic [CFG_W-1:0]              wr_data,
	srm_req_if.sink                       req,
	srm_rsp_if.source                     rsp
);
	import srm_pkg::*;

	// value range limits and saturated min/max start-up values
	localparam longint VMAX_L = (longint'(1) <<< (VALUE_BITS - 1)) - 1;
	localparam longint VMIN_L = -(longint'(1) <<< (VALUE_BITS - 1));
	localparam longint MIN_RST_L = (MINMAX_INIT > VMAX_L) ? VMAX_L : MINMAX_INIT;
	localparam longint MAX_RST_L = (-MINMAX_INIT < VMIN_L) ? VMIN_L : -MINMAX_INIT;
	localparam logic signed [VALUE_BITS-1:0] MIN_RST = VALUE_BITS'(MIN_RST_L);
	localparam logic signed [VALUE_BITS-1:0] MAX_RST = VALUE_BITS'(MAX_RST_L);
	localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
	// width for the change compare: the signed diff needs VALUE_BITS+1 bits
	localparam int DW = VALUE_BITS + 1;
	localparam int CW = (DW > THRESH_W) ? DW : THRESH_W;

	// ---------------- configuration registers ----------------
	// The period is kept in ms, multiplied out as the minutes register is
	// written; zero minutes gives a zero period and disables cyclic sending.
	logic [TIME_W-1:0]            period_q;
	logic [THRESH_W-1:0]          thresh_q;
	logic signed [VALUE_BITS-1:0] offset_q;
	logic signed [VALUE_BITS-1:0] warn_low_q;
	logic signed [VALUE_BITS-1:0] warn_high_q;
	logic                         minmax_en_q;
	logic [CYCLE_W+MSPM_W-1:0]    period_prod;

	assign period_prod = wr_data[CYCLE_W-1:0] * MSPM_W'(MS_PER_MINUTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= '0;
			thresh_q    <= '0;
			offset_q    <= '0;
			warn_low_q  <= '0;
			warn_high_q <= '0;
			minmax_en_q <= 1'b0;
		end else if (wr_en) begin
			case (wr_index)
				REG_SEND_CYCLE: period_q    <= TIME_W'(period_prod);
				REG_THRESHOLD:  thresh_q    <= wr_data[THRESH_W-1:0];
				REG_OFFSET:     offset_q    <= wr_data[VALUE_BITS-1:0];
				REG_WARN_LOW:   warn_low_q  <= wr_data[VALUE_BITS-1:0];
				REG_WARN_HIGH:  warn_high_q <= wr_data[VALUE_BITS-1:0];
				REG_MINMAX_EN:  minmax_en_q <= wr_data[0];
				default: ;  // unused indexes are dropped
			endcase
		end
	end

	// ---------------- input register ----------------
	logic                         valid_s1;
	logic                         req_type_s1;
	logic signed [VALUE_BITS-1:0] raw_s1;
	logic                         svalid_s1;
	logic [TIME_W-1:0]            now_s1;
	logic                         out_valid_q;
	logic                         advance;

	// stage 1 moves on whenever the report register is empty or being drained
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1 <= req.req_type;
			raw_s1      <= req.sample_value;
			svalid_s1   <= req.sample_valid;
			now_s1      <= req.now_ms;
		end
	end

	// ---------------- channel state ----------------
	logic [TIME_W-1:0]            last_time_q;
	logic                         ever_sent_q;
	logic signed [VALUE_BITS-1:0] last_sample_q;
	logic signed [VALUE_BITS-1:0] report_q;
	logic signed [VALUE_BITS-1:0] min_q;
	logic signed [VALUE_BITS-1:0] max_q;
	logic                         hi_state_q;
	logic                         lo_state_q;
	logic [TIME_W-1:0]            hi_time_q;
	logic [TIME_W-1:0]            lo_time_q;

	// ---------------- evaluation ----------------
	logic signed [VALUE_BITS:0]   sum;
	logic signed [VALUE_BITS-1:0] v;
	logic signed [VALUE_BITS:0]   diff;
	logic [DW-1:0]                abs_diff;
	logic                         exp_val, exp_hi, exp_lo;
	logic                         is_sample, is_mm_reset;
	logic                         send, send_cyc, send_dlt;
	logic                         alarms_on, ah, al;
	logic                         hi_send, lo_send;
	logic signed [VALUE_BITS-1:0] min_nx, max_nx;

	srm_elapsed u_exp_val (.now(now_s1), .since(last_time_q), .period(period_q),
		.expired(exp_val));
	srm_elapsed u_exp_hi (.now(now_s1), .since(hi_time_q), .period(period_q),
		.expired(exp_hi));
	srm_elapsed u_exp_lo (.now(now_s1), .since(lo_time_q), .period(period_q),
		.expired(exp_lo));

	always_comb begin
		is_mm_reset = (req_type_s1 == REQ_MINMAX_RESET);
		is_sample   = (req_type_s1 == REQ_SAMPLE) && svalid_s1;

		// offset correction with saturation
		sum = {raw_s1[VALUE_BITS-1], raw_s1} + {offset_q[VALUE_BITS-1], offset_q};
		if (sum[VALUE_BITS] != sum[VALUE_BITS-1])
			v = sum[VALUE_BITS] ? VMIN : VMAX;
		else
			v = sum[VALUE_BITS-1:0];

		// send decision: cyclic/first send, else raw change since last send
		send_cyc = (period_q != '0) && (exp_val || !ever_sent_q);
		diff     = {raw_s1[VALUE_BITS-1], raw_s1} - {last_sample_q[VALUE_BITS-1], last_sample_q};
		abs_diff = diff[VALUE_BITS] ? DW'(-diff) : DW'(diff);
		send_dlt = (thresh_q != '0) && (CW'(abs_diff) >= CW'(thresh_q));
		send     = send_cyc || send_dlt;

		// min/max tracking
		min_nx = min_q;
		max_nx = max_q;
		if (is_mm_reset) begin
			min_nx = report_q;
			max_nx = report_q;
		end else if (is_sample && minmax_en_q) begin
			if (v > max_q) max_nx = v;
			if (v < min_q) min_nx = v;
		end

		// alarms: sent on change, or again once the period has run out while the alarm stands; off while both limits are zero
		alarms_on = !((warn_low_q == '0) && (warn_high_q == '0));
		ah        = v > warn_high_q;
		al        = v < warn_low_q;
		hi_send   = is_sample && alarms_on && ((hi_state_q != ah) || (ah && exp_hi));
		lo_send   = is_sample && alarms_on && ((lo_state_q != al) || (al && exp_lo));
	end

	// ---------------- state update ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q   <= '0;
			ever_sent_q   <= 1'b0;
			last_sample_q <= '0;
			report_q      <= '0;
			min_q         <= MIN_RST;
			max_q         <= MAX_RST;
			hi_state_q    <= 1'b0;
			lo_state_q    <= 1'b0;
			hi_time_q     <= '0;
			lo_time_q     <= '0;
		end else if (advance) begin
			min_q <= min_nx;
			max_q <= max_nx;
			if (is_sample) begin
				report_q <= v;
				if (send) begin
					last_time_q   <= now_s1;
					ever_sent_q   <= 1'b1;
					last_sample_q <= raw_s1;
				end
			end
			if (hi_send) begin
				hi_state_q <= ah;
				hi_time_q  <= now_s1;
			end
			if (lo_send) begin
				lo_state_q <= al;
				lo_time_q  <= now_s1;
			end
		end
	end

	// ---------------- report register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || rsp.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.reported_value  <= is_sample ? v : report_q;
			rsp.value_sent      <= is_sample && send;
			rsp.min_value       <= min_nx;
			rsp.max_value       <= max_nx;
			rsp.alarm_high      <= hi_send ? ah : hi_state_q;
			rsp.alarm_high_sent <= hi_send;
			rsp.alarm_low       <= lo_send ? al : lo_state_q;
			rsp.alarm_low_sent  <= lo_send;
		end
	end

	assign rsp.valid = out_valid_q;
endmodule

### hw/rtl/srm_checker.sv
// Port-level checks for the monitor core, bound to the top level.
// Depends on no package; widths follow the bound core's VALUE_BITS.
module srm_checker #(
	parameter int VALUE_BITS = 24
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [VALUE_BITS-1:0] out_value,
	input logic [VALUE_BITS-1:0] out_min,
	input logic [VALUE_BITS-1:0] out_max,
	input logic [5:0]            out_flags
);
	// a stalled report stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("report dropped while stalled");

	// and its contents do not move
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({out_value, out_min, out_max, out_flags}))
		else $error("report changed while stalled");

	// the request side only stalls when the report register is full and held
	a_ready_skid: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request stalled with room downstream");

	// a report appearing from empty comes from a request transfer through the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("report without matching request transfer");
endmodule

bind sensor_report_and_alarm_monitor_core srm_checker #(.VALUE_BITS(VALUE_BITS)) u_srm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_value (rsp.reported_value),
	.out_min   (rsp.min_value),
	.out_max   (rsp.max_value),
	.out_flags ({rsp.value_sent, rsp.alarm_high, rsp.alarm_high_sent,
		rsp.alarm_low, rsp.alarm_low_sent, 1'b0})
);
